// ===== design/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared constants, types and codes for the two-heap running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int MAX_COUNT  = 1024;
    localparam int SAMPLE_W   = 32;
    localparam int MED_W      = SAMPLE_W + 1;
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);
    // Two spare slots beyond half the store cover the transient extra element before a rebalance.
    localparam int HEAP_DEPTH = MAX_COUNT / 2 + 2;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PU_START,
        ST_PU_RD,
        ST_PU_STEP,
        ST_AFTER_PUSH,
        ST_PO_LAST,
        ST_PO_RDL,
        ST_PO_RDR,
        ST_PO_STEP,
        ST_PO_FIN,
        ST_MOVE,
        ST_RESULT
    } ctl_state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_SAMPLE,
        DP_PUSH_START,
        DP_PUSH_READ,
        DP_PUSH_STEP,
        DP_POP_START,
        DP_POP_LAST,
        DP_POP_READ_L,
        DP_POP_READ_R,
        DP_POP_STEP,
        DP_POP_FINISH,
        DP_MOVE,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   heap_up;   // 1 selects the upper (min) heap
        logic   drop;      // result reports a discarded sample
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic go_upper;
        logic idx_zero;
        logic push_stop;
        logic no_child;
        logic pop_stop;
        logic up_heavy;
        logic lo_heavy;
    } dp_stat_t;

endpackage

// ===== design/rmth_ram.sv =====
// ----------------------------------------------------------------------------
// rmth_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rmth_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rmth_datapath.sv =====
// ----------------------------------------------------------------------------
// rmth_datapath
// Heap memories, counts, cached heap tops, sift registers and result register.
// ----------------------------------------------------------------------------
module rmth_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rmth_pkg::dp_cmd_t             cmd,
    output rmth_pkg::dp_stat_t            stat,
    input  logic signed [rmth_pkg::SAMPLE_W-1:0] sample,
    output logic signed [rmth_pkg::MED_W-1:0]    median_doubled,
    output logic [rmth_pkg::CNT_W-1:0]           stored_count,
    output logic                                 sample_dropped
);

    localparam int IW = rmth_pkg::IDX_W;
    localparam int SW = rmth_pkg::SAMPLE_W;

    logic signed [SW-1:0] val_reg, val_next;
    logic signed [SW-1:0] kid_reg, kid_next;
    logic signed [SW-1:0] mv_reg, mv_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        lo_cnt_reg, lo_cnt_next;
    logic [IW-1:0]        up_cnt_reg, up_cnt_next;
    logic signed [SW-1:0] lo_top_reg, lo_top_next;
    logic signed [SW-1:0] up_top_reg, up_top_next;

    logic signed [rmth_pkg::MED_W-1:0] med_reg, med_next;
    logic [rmth_pkg::CNT_W-1:0]        cnt_out_reg, cnt_out_next;
    logic                              drop_reg, drop_next;

    logic                 we;
    logic [IW-1:0]        waddr, raddr;
    logic signed [SW-1:0] wdata;
    logic signed [SW-1:0] rdata, rdata_lo, rdata_up;

    logic [IW-1:0]        cnt;
    logic signed [SW-1:0] top;
    logic [IW-1:0]        parent;
    logic [IW:0]          child_l, child_r;
    logic                 has_r, pick_r;
    logic signed [SW-1:0] cand;
    logic [IW-1:0]        cand_idx;
    logic [rmth_pkg::CNT_W-1:0] total;
    logic signed [rmth_pkg::MED_W-1:0] lo_v, up_v;

    // Heap order: the upper heap keeps its minimum on top, the lower its maximum.
    function automatic logic better(input logic heap_up, input logic signed [SW-1:0] a,
                                    input logic signed [SW-1:0] b);
        better = heap_up ? (a < b) : (a > b);
    endfunction

    rmth_ram #(.DEPTH(rmth_pkg::HEAP_DEPTH), .WIDTH(SW), .AW(IW)) u_lo_ram (
        .clk   (clk),
        .we    (we && !cmd.heap_up),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_lo)
    );

    rmth_ram #(.DEPTH(rmth_pkg::HEAP_DEPTH), .WIDTH(SW), .AW(IW)) u_up_ram (
        .clk   (clk),
        .we    (we && cmd.heap_up),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_up)
    );

    // Selected heap and address arithmetic.
    assign rdata    = cmd.heap_up ? rdata_up : rdata_lo;
    assign cnt      = cmd.heap_up ? up_cnt_reg : lo_cnt_reg;
    assign top      = cmd.heap_up ? up_top_reg : lo_top_reg;
    assign parent   = IW'(idx_reg - 1'b1) >> 1;
    assign child_l  = {idx_reg, 1'b1};
    assign child_r  = child_l + 1'b1;
    assign has_r    = child_r < {1'b0, cnt};
    assign pick_r   = has_r && better(cmd.heap_up, rdata, kid_reg);
    assign cand     = pick_r ? rdata : kid_reg;
    assign cand_idx = pick_r ? child_r[IW-1:0] : child_l[IW-1:0];
    assign total    = rmth_pkg::CNT_W'(lo_cnt_reg) + rmth_pkg::CNT_W'(up_cnt_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.full      = (total == rmth_pkg::CNT_W'(rmth_pkg::MAX_COUNT));
        stat.go_upper  = (lo_cnt_reg == '0) || (val_reg > lo_top_reg);
        stat.idx_zero  = (idx_reg == '0);
        stat.push_stop = !better(cmd.heap_up, val_reg, rdata);
        stat.no_child  = child_l >= {1'b0, cnt};
        stat.pop_stop  = !better(cmd.heap_up, cand, val_reg);
        stat.up_heavy  = {1'b0, up_cnt_reg} > ({1'b0, lo_cnt_reg} + 1'b1);
        stat.lo_heavy  = lo_cnt_reg > up_cnt_reg;
    end

    // Median from the cached tops; an empty heap contributes zero.
    assign lo_v = (lo_cnt_reg != '0) ? rmth_pkg::MED_W'(lo_top_reg) : '0;
    assign up_v = (up_cnt_reg != '0) ? rmth_pkg::MED_W'(up_top_reg) : '0;

    // Operation decode.
    always_comb
    begin
        val_next     = val_reg;
        kid_next     = kid_reg;
        mv_next      = mv_reg;
        idx_next     = idx_reg;
        lo_cnt_next  = lo_cnt_reg;
        up_cnt_next  = up_cnt_reg;
        med_next     = med_reg;
        cnt_out_next = cnt_out_reg;
        drop_next    = drop_reg;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = val_reg;
        raddr        = parent;
        unique case (cmd.op)
            rmth_pkg::DP_NOP:
            begin
            end
            rmth_pkg::DP_LOAD_SAMPLE:
            begin
                val_next = sample;
            end
            rmth_pkg::DP_PUSH_START:
            begin
                idx_next = cnt;
                if (cmd.heap_up)
                    up_cnt_next = up_cnt_reg + 1'b1;
                else
                    lo_cnt_next = lo_cnt_reg + 1'b1;
            end
            rmth_pkg::DP_PUSH_READ:
            begin
                raddr = parent;
                we    = (idx_reg == '0);
            end
            rmth_pkg::DP_PUSH_STEP:
            begin
                we = 1'b1;
                if (!stat.push_stop)
                begin
                    wdata    = rdata;
                    idx_next = parent;
                end
            end
            rmth_pkg::DP_POP_START:
            begin
                mv_next  = top;
                idx_next = '0;
                raddr    = cnt - 1'b1;
                if (cmd.heap_up)
                    up_cnt_next = up_cnt_reg - 1'b1;
                else
                    lo_cnt_next = lo_cnt_reg - 1'b1;
            end
            rmth_pkg::DP_POP_LAST:
            begin
                val_next = rdata;
            end
            rmth_pkg::DP_POP_READ_L:
            begin
                raddr = child_l[IW-1:0];
            end
            rmth_pkg::DP_POP_READ_R:
            begin
                kid_next = rdata;
                raddr    = child_r[IW-1:0];
            end
            rmth_pkg::DP_POP_STEP:
            begin
                if (!stat.pop_stop)
                begin
                    we       = 1'b1;
                    wdata    = cand;
                    idx_next = cand_idx;
                end
            end
            rmth_pkg::DP_POP_FINISH:
            begin
                we = (cnt != '0);
            end
            rmth_pkg::DP_MOVE:
            begin
                val_next = mv_reg;
            end
            rmth_pkg::DP_RESULT:
            begin
                med_next     = (lo_cnt_reg == up_cnt_reg) ? lo_v + up_v : up_v + up_v;
                cnt_out_next = total;
                drop_next    = cmd.drop;
            end
            default:
            begin
            end
        endcase
    end

    // A write to the root refreshes the cached top of that heap.
    always_comb
    begin
        lo_top_next = lo_top_reg;
        up_top_next = up_top_reg;
        if (we && waddr == '0)
        begin
            if (cmd.heap_up)
                up_top_next = wdata;
            else
                lo_top_next = wdata;
        end
    end

    // Control counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_cnt_reg <= '0;
            up_cnt_reg <= '0;
        end
        else
        begin
            lo_cnt_reg <= lo_cnt_next;
            up_cnt_reg <= up_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        kid_reg     <= kid_next;
        mv_reg      <= mv_next;
        idx_reg     <= idx_next;
        lo_top_reg  <= lo_top_next;
        up_top_reg  <= up_top_next;
        med_reg     <= med_next;
        cnt_out_reg <= cnt_out_next;
        drop_reg    <= drop_next;
    end

    assign median_doubled = med_reg;
    assign stored_count   = cnt_out_reg;
    assign sample_dropped = drop_reg;

endmodule

// ===== design/rmth_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmth_ctrl
// Sequencer for insert, rebalance and result hand-off.
// ----------------------------------------------------------------------------
module rmth_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rmth_pkg::dp_cmd_t        cmd,
    input  rmth_pkg::dp_stat_t       stat
);

    rmth_pkg::ctl_state_t state_reg, state_next;
    logic sel_reg, sel_next;
    logic second_reg, second_next;
    logic drop_reg, drop_next;
    logic out_valid_reg, out_valid_next;

    // State and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmth_pkg::ST_IDLE;
            sel_reg       <= 1'b0;
            second_reg    <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            second_reg    <= second_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        second_next    = second_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = rmth_pkg::DP_NOP;
        cmd.heap_up    = sel_reg;
        cmd.drop       = drop_reg;
        unique case (state_reg)
            rmth_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op      = rmth_pkg::DP_LOAD_SAMPLE;
                    second_next = 1'b0;
                    state_next  = rmth_pkg::ST_DECIDE;
                end
            end
            rmth_pkg::ST_DECIDE:
            begin
                drop_next = stat.full;
                sel_next  = stat.go_upper;
                state_next = stat.full ? rmth_pkg::ST_RESULT : rmth_pkg::ST_PU_START;
            end
            rmth_pkg::ST_PU_START:
            begin
                cmd.op     = rmth_pkg::DP_PUSH_START;
                state_next = rmth_pkg::ST_PU_RD;
            end
            rmth_pkg::ST_PU_RD:
            begin
                cmd.op     = rmth_pkg::DP_PUSH_READ;
                state_next = stat.idx_zero ? rmth_pkg::ST_AFTER_PUSH : rmth_pkg::ST_PU_STEP;
            end
            rmth_pkg::ST_PU_STEP:
            begin
                cmd.op     = rmth_pkg::DP_PUSH_STEP;
                state_next = stat.push_stop ? rmth_pkg::ST_AFTER_PUSH : rmth_pkg::ST_PU_RD;
            end
            rmth_pkg::ST_AFTER_PUSH:
            begin
                if (second_reg)
                    state_next = rmth_pkg::ST_RESULT;
                else if (sel_reg ? stat.up_heavy : stat.lo_heavy)
                begin
                    cmd.op     = rmth_pkg::DP_POP_START;
                    state_next = rmth_pkg::ST_PO_LAST;
                end
                else
                    state_next = rmth_pkg::ST_RESULT;
            end
            rmth_pkg::ST_PO_LAST:
            begin
                cmd.op     = rmth_pkg::DP_POP_LAST;
                state_next = rmth_pkg::ST_PO_RDL;
            end
            rmth_pkg::ST_PO_RDL:
            begin
                cmd.op     = rmth_pkg::DP_POP_READ_L;
                state_next = stat.no_child ? rmth_pkg::ST_PO_FIN : rmth_pkg::ST_PO_RDR;
            end
            rmth_pkg::ST_PO_RDR:
            begin
                cmd.op     = rmth_pkg::DP_POP_READ_R;
                state_next = rmth_pkg::ST_PO_STEP;
            end
            rmth_pkg::ST_PO_STEP:
            begin
                cmd.op     = rmth_pkg::DP_POP_STEP;
                state_next = stat.pop_stop ? rmth_pkg::ST_PO_FIN : rmth_pkg::ST_PO_RDL;
            end
            rmth_pkg::ST_PO_FIN:
            begin
                cmd.op     = rmth_pkg::DP_POP_FINISH;
                state_next = rmth_pkg::ST_MOVE;
            end
            rmth_pkg::ST_MOVE:
            begin
                // The popped top moves into the other heap.
                cmd.op      = rmth_pkg::DP_MOVE;
                sel_next    = !sel_reg;
                second_next = 1'b1;
                state_next  = rmth_pkg::ST_PU_START;
            end
            rmth_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = rmth_pkg::DP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = rmth_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmth_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/running_median_two_heaps.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median over a lower max-heap and an upper min-heap.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result: twice the median of all stored
// samples, the stored count, and a flag set when the store already held
// 1024 samples and the sample was discarded. One sample is processed at a
// time. The processing time of an item is set by the heap sifts, which make
// one access to a single-port-read heap memory per step, two states per
// level on a sift up (read, step) and three on a sift down (read left, read
// right, step), over up to nine levels. A dropped sample skips the sifts, and
// a rebalance adds a sift down and a second sift up. The result sits
// in an output register, so the next sample is taken while the previous
// result waits.
module running_median_two_heaps (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [rmth_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rmth_pkg::MED_W-1:0]    median_doubled,
    output logic [rmth_pkg::CNT_W-1:0]           stored_count,
    output logic                                 sample_dropped
);

    rmth_pkg::dp_cmd_t  cmd;
    rmth_pkg::dp_stat_t stat;

    rmth_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    rmth_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .sample         (sample),
        .median_doubled (median_doubled),
        .stored_count   (stored_count),
        .sample_dropped (sample_dropped)
    );

endmodule

// ===== design/rmth_checker.sv =====
// ----------------------------------------------------------------------------
// rmth_checker
// Port-level checks for the running median block, bound to the top level.
// ----------------------------------------------------------------------------
module rmth_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [rmth_pkg::MED_W-1:0]    median_doubled,
    input logic [rmth_pkg::CNT_W-1:0]           stored_count,
    input logic                                 sample_dropped
);

    // A shown result never exceeds the store size and is never empty.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stored_count != '0 &&
                       stored_count <= rmth_pkg::CNT_W'(rmth_pkg::MAX_COUNT)))
        else $error("stored_count out of range");

    // A discarded sample only happens with a full store.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sample_dropped) |->
            stored_count == rmth_pkg::CNT_W'(rmth_pkg::MAX_COUNT))
        else $error("drop reported without a full store");

    // A stalled result keeps its median and count.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(median_doubled) && $stable(stored_count)))
        else $error("stalled result changed");

    // The block never takes a transaction in the cycle right after one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while busy");

endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .median_doubled (median_doubled),
    .stored_count   (stored_count),
    .sample_dropped (sample_dropped)
);
